>>> rtl/sorted_priority_queue_core_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Types and constants of the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int PRIO_W   = 16;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 5;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_REMOVE = 1'b1
	} spq_mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} spq_status_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic signed [PRIO_W-1:0] prio;
	} spq_entry_t;

	// broadcast to every cell each cycle
	typedef struct packed {
		logic       ins;
		logic       rem;
		spq_entry_t ent;
	} spq_cell_ctl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic       occ;
		logic       greater;
		spq_entry_t ent;
	} spq_link_t;

	typedef struct packed {
		spq_status_t              status;
		logic signed [DATA_W-1:0] data_out;
		logic signed [PRIO_W-1:0] priority_out;
		logic [COUNT_W-1:0]       count_out;
	} spq_result_t;

endpackage

>>> rtl/spq_if.sv
// Valid/ready channel interfaces for request and response items.
interface spq_req_if;
	import spq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic signed [DATA_W-1:0] data_in;
	logic signed [PRIO_W-1:0] priority_in;

	modport source (output valid, mode, data_in, priority_in, input ready);
	modport sink   (input valid, mode, data_in, priority_in, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] data_out;
	logic signed [PRIO_W-1:0] priority_out;
	logic [COUNT_W-1:0]       count_out;

	modport source (output valid, status, data_out, priority_out, count_out, input ready);
	modport sink   (input valid, status, data_out, priority_out, count_out, output ready);
endinterface

>>> rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: cell chain, fill count and result buffer.
//
// Usage:
//   req channel: mode (insert or remove), data_in, priority_in. An item is
//   taken when req.valid and req.ready are both high at a clock edge.
//   rsp channel: exactly one item per request: status, data_out,
//   priority_out and count_out (entries held after the operation).
//   Entries sit in a row of CAPACITY cells sorted by ascending signed
//   priority; equal priorities leave in arrival order. An insert makes
//   every cell compare against the new entry and shift right; a remove
//   shifts the whole row left by one cell.
//   Responses go to the output register, or to the skid slot while that
//   register holds an untaken item. One item per cycle while req.ready is high.
//   An insert into a full queue is dropped with status full; a remove from
//   an empty queue returns status empty with zero data.
//   Reset (arst_n low) empties the queue and drops any pending responses;
//   cell contents are not cleared, the fill count alone marks them.
//   Receiver stall: a two-deep response buffer (output register plus skid)
//   keeps taking requests until both slots hold items, then drops req.ready.
`include "sorted_priority_queue_core_macros.svh"

module sorted_priority_queue_core
	import spq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	logic [CNT_W-1:0] count_q;
	logic             main_v_q;
	logic             skid_v_q;
	spq_result_t      main_q;
	spq_result_t      skid_q;

	logic             acc;
	logic             pop;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] count_nxt;
	spq_cell_ctl_t    ctl;
	spq_result_t      res;
	spq_link_t        links [CAPACITY];
	spq_link_t        prevs [CAPACITY];
	spq_link_t        nexts [CAPACITY];

	assign acc   = req.valid && req.ready;
	assign pop   = rsp.valid && rsp.ready;
	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign ctl.ins      = acc && (req.mode == MODE_INSERT) && !full;
	assign ctl.rem      = acc && (req.mode == MODE_REMOVE) && !empty;
	assign ctl.ent.data = req.data_in;
	assign ctl.ent.prio = req.priority_in;

	// ---- cell chain ----
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prevs[i] = '{occ: 1'b1, greater: 1'b0, ent: '0};
		end else begin : g_mid
			assign prevs[i] = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign nexts[i] = links[i];
		end else begin : g_body
			assign nexts[i] = links[i+1];
		end

		spq_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.occ  (count_q > CNT_W'(i)),
			.prev (prevs[i]),
			.next (nexts[i]),
			.link (links[i])
		);
	end

	// ---- fill count and result ----
	always_comb begin
		count_nxt = count_q;
		res       = '{status: ST_INSERTED, data_out: '0, priority_out: '0, count_out: '0};
		unique case (req.mode)
			MODE_INSERT: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					count_nxt        = count_q - 1'b1;
					res.status       = ST_REMOVED;
					res.data_out     = links[0].ent.data;
					res.priority_out = links[0].ent.prio;
				end
			end
			default: begin
				res.status = ST_EMPTY;
			end
		endcase
		res.count_out = COUNT_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (acc) begin
			count_q <= count_nxt;
		end
	end

	// ---- response buffer: output register plus skid slot ----
	assign req.ready = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			priority if (acc && (!main_v_q || pop)) begin
				main_v_q <= 1'b1;
			end else if (acc) begin
				skid_v_q <= 1'b1;
			end else if (pop) begin
				main_v_q <= skid_v_q;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= main_v_q;
				skid_v_q <= skid_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (acc && (!main_v_q || pop)) begin
			main_q <= res;
		end else if (acc) begin
			skid_q <= res;
		end else if (pop && skid_v_q) begin
			main_q <= skid_q;
		end else begin
			main_q <= main_q;
		end
	end

	assign rsp.valid        = main_v_q;
	assign rsp.status       = main_q.status;
	assign rsp.data_out     = main_q.data_out;
	assign rsp.priority_out = main_q.priority_out;
	assign rsp.count_out    = main_q.count_out;

	// ---- checks ----
	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "fill count over capacity")
	`SPQ_ASSERT_NEXT(a_count_ins, ctl.ins, count_q == $past(count_q) + 1'b1, "insert did not count")
	`SPQ_ASSERT_NOW(a_skid_order, skid_v_q, main_v_q, "skid holds an item ahead of output")
	`SPQ_ASSERT_NOW(a_head_sorted, count_q >= CNT_W'(2),
		$signed(links[0].ent.prio) <= $signed(links[1].ent.prio), "head out of order")

endmodule

>>> rtl/spq_cell.sv
// One storage cell of the sorted chain: compare with the new entry and shift.
module spq_cell
	import spq_pkg::*;
(
	input  logic          clk,
	input  spq_cell_ctl_t ctl,
	input  logic          occ,
	input  spq_link_t     prev,
	input  spq_link_t     next,
	output spq_link_t     link
);

	spq_entry_t entry_q;
	logic       greater;

	// strictly greater: equal priorities stay ahead of the new entry
	assign greater = occ && ($signed(entry_q.prio) > $signed(ctl.ent.prio));

	always_ff @(posedge clk) begin
		priority if (ctl.ins) begin
			priority if (prev.greater) begin
				entry_q <= prev.ent;
			end else if ((greater || !occ) && prev.occ) begin
				entry_q <= ctl.ent;
			end else begin
				entry_q <= entry_q;
			end
		end else if (ctl.rem) begin
			entry_q <= next.ent;
		end else begin
			entry_q <= entry_q;
		end
	end

	assign link.occ     = occ;
	assign link.greater = greater;
	assign link.ent     = entry_q;

endmodule
